FILE: hw/rtl/pngfe_pkg.sv
// Package for the PNG scanline filter encoder: shared types, codes and constants.
// Used by every module under hw/rtl except pngfe_ram; depends on nothing.
package pngfe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_BPP      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN = 1'd1;

    // Left-neighbour distance limit and history depth (power of two)
    localparam logic [3:0] MAX_BPP   = 4'd8;
    localparam int         HIST_DEPTH = 8;
    localparam int         HIST_W     = 3;

    // Queue between front and back (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Filter type codes; 5 to 7 behave as none
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Classified word leaving the front stage
    typedef struct packed {
        logic [7:0]        pixel;
        logic [2:0]        filt;
        logic              no_prev;
        logic              have_left;
        logic [HIST_W-1:0] hidx;
        logic [HIST_W-1:0] widx;
        logic              last;
    } front_item_t;

    // Queue entry: classified word plus the byte above it
    typedef struct packed {
        front_item_t item;
        logic [7:0]  above;
    } entry_t;

endpackage

FILE: hw/rtl/pngfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pngfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/pngfe_front.sv
// Front stage: configuration registers, column tracking, line store access
// and classification of each input word. Uses pngfe_pkg and pngfe_ram.
module pngfe_front #(
    parameter int MAX_LINE_BYTES = 4096,
    localparam int COL_W = $clog2(MAX_LINE_BYTES)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pngfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pngfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic [3:0]                          s_tuser,
    input  logic [pngfe_pkg::Q_CNT_W-1:0]       q_level,
    output logic                                q_push,
    output pngfe_pkg::entry_t                   q_entry
);

    logic [3:0]                      bpp_reg;
    logic [pngfe_pkg::CFG_DATA_W-1:0] len_reg;
    logic [COL_W-1:0]                col_reg;
    logic [COL_W-1:0]                col_next;
    logic                            s1_valid_reg;
    pngfe_pkg::front_item_t          s1_item_reg;

    logic [3:0]       bpp_eff;
    logic [COL_W:0]   len_eff;
    logic [COL_W:0]   col_inc;
    logic             last;
    logic             accept;
    logic [7:0]       above_rd;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= 4'd1;
            len_reg <= 13'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                pngfe_pkg::REG_BPP:      bpp_reg <= cfg_wdata[3:0];
                pngfe_pkg::REG_LINE_LEN: len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the registers to their usable ranges
    always_comb begin
        if (bpp_reg == 4'd0) begin
            bpp_eff = 4'd1;
        end else if (bpp_reg > pngfe_pkg::MAX_BPP) begin
            bpp_eff = pngfe_pkg::MAX_BPP;
        end else begin
            bpp_eff = bpp_reg;
        end
        if (len_reg == '0) begin
            len_eff = (COL_W+1)'(1);
        end else if (32'(len_reg) > MAX_LINE_BYTES) begin
            len_eff = (COL_W+1)'(MAX_LINE_BYTES);
        end else begin
            len_eff = (COL_W+1)'(len_reg);
        end
    end

    // Reserve a queue slot for the word still in the front register
    assign s_tready = (32'(q_level) + 32'(s1_valid_reg)) < pngfe_pkg::Q_DEPTH;
    assign accept   = s_tvalid & s_tready;

    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
    assign last     = col_inc >= len_eff;
    assign col_next = last ? '0 : col_inc[COL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg.pixel     <= s_tdata;
            s1_item_reg.filt      <= s_tuser[2:0];
            s1_item_reg.no_prev   <= s_tuser[3];
            s1_item_reg.have_left <= 32'(col_reg) >= 32'(bpp_eff);
            s1_item_reg.hidx      <= col_reg[pngfe_pkg::HIST_W-1:0]
                                     - bpp_eff[pngfe_pkg::HIST_W-1:0];
            s1_item_reg.widx      <= col_reg[pngfe_pkg::HIST_W-1:0];
            s1_item_reg.last      <= last;
        end
    end

    // Read the byte above before overwriting it with this line's byte
    pngfe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (above_rd)
    );

    assign q_push        = s1_valid_reg;
    assign q_entry.item  = s1_item_reg;
    assign q_entry.above = s1_item_reg.no_prev ? 8'd0 : above_rd;

endmodule

FILE: hw/rtl/pngfe_queue.sv
// Short queue of classified words between the front and back stages.
// Uses pngfe_pkg.
module pngfe_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  pngfe_pkg::entry_t             push_entry,
    input  logic                          pop_ready,
    output logic                          out_valid,
    output pngfe_pkg::entry_t             out_entry,
    output logic [pngfe_pkg::Q_CNT_W-1:0] level
);

    pngfe_pkg::entry_t                    slot_reg [0:pngfe_pkg::Q_DEPTH-1];
    logic [pngfe_pkg::Q_PTR_W-1:0]        wr_ptr_reg;
    logic [pngfe_pkg::Q_PTR_W-1:0]        rd_ptr_reg;
    logic [pngfe_pkg::Q_CNT_W-1:0]        level_reg;
    logic                                 pop;

    assign out_valid = level_reg != '0;
    assign out_entry = slot_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_reg + pngfe_pkg::Q_CNT_W'(push)
                                   - pngfe_pkg::Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/pngfe_back.sv
// Back stage: left and upper-left history, prediction, subtraction and the
// output register. Uses pngfe_pkg.
module pngfe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  pngfe_pkg::entry_t in_entry,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    logic [7:0] left_hist_reg [0:pngfe_pkg::HIST_DEPTH-1];
    logic [7:0] ul_hist_reg   [0:pngfe_pkg::HIST_DEPTH-1];
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic       fire;
    logic [7:0] a_val;
    logic [7:0] b_val;
    logic [7:0] c_val;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] filtered;

    // Nearest of a, b, c to a+b-c; ties prefer a, then b
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] sab;
        logic [9:0] cc;
        pa  = (b > c) ? 10'(b) - 10'(c) : 10'(c) - 10'(b);
        pb  = (a > c) ? 10'(a) - 10'(c) : 10'(c) - 10'(a);
        sab = 10'(a) + 10'(b);
        cc  = {1'b0, c, 1'b0};
        pc  = (sab > cc) ? sab - cc : cc - sab;
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    endfunction

    assign in_ready = !out_valid_reg || m_tready;
    assign fire     = in_valid & in_ready;

    always_comb begin
        a_val  = in_entry.item.have_left ? left_hist_reg[in_entry.item.hidx] : 8'd0;
        c_val  = in_entry.item.have_left ? ul_hist_reg[in_entry.item.hidx] : 8'd0;
        b_val  = in_entry.above;
        ab_sum = 9'(a_val) + 9'(b_val);
        case (in_entry.item.filt)
            pngfe_pkg::FILT_SUB:   pred = a_val;
            pngfe_pkg::FILT_UP:    pred = b_val;
            pngfe_pkg::FILT_AVG:   pred = ab_sum[8:1];
            pngfe_pkg::FILT_PAETH: pred = paeth(a_val, b_val, c_val);
            default:               pred = 8'd0;
        endcase
        filtered = in_entry.item.pixel - pred;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < pngfe_pkg::HIST_DEPTH; i++) begin
                left_hist_reg[i] <= 8'd0;
                ul_hist_reg[i]   <= 8'd0;
            end
        end else begin
            if (fire) begin
                out_valid_reg                    <= 1'b1;
                left_hist_reg[in_entry.item.widx] <= in_entry.item.pixel;
                ul_hist_reg[in_entry.item.widx]   <= b_val;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= filtered;
            out_last_reg <= in_entry.item.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/png_scanline_filter_encoder_core.sv
// PNG scanline filter encoder, top level: front stage, queue and back stage.
// Uses pngfe_pkg, pngfe_front (with pngfe_ram), pngfe_queue and pngfe_back.
//
// Usage: raw scanline bytes enter on the s_ stream, one byte per word, with
// the filter type and a "no line above" flag in s_tuser. Each word leaves on
// the m_ stream as the filtered byte (raw minus prediction, modulo 256);
// m_tlast marks the last byte of each scanline. Set bytes_per_pixel and
// line_length through the cfg_ write port while no word is in flight.
// Throughput: one word per clock while m_tready stays high, set by the single-port-pair line store,
// which is read and written at the same column in the accept cycle.
// From input accept to m_tvalid a word passes the line store read, the
// queue and the output register.
// Reset (aresetn low, synchronous): column returns to zero, histories clear,
// bytes_per_pixel and line_length return to 1; the line store keeps its
// contents and must be written by a first line before it is referenced.
// Stall: when m_tready is low the output register holds its word, the
// queue fills and s_tready drops once the queue has no free slot; no word
// is lost or repeated.
module png_scanline_filter_encoder_core #(
    parameter int MAX_LINE_BYTES = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [pngfe_pkg::CFG_IDX_W-1:0]  cfg_index,  // 0 bytes_per_pixel, 1 line_length
    input  logic [pngfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,    // [7:0] pixel_byte
    input  logic [3:0]                       s_tuser,    // [2:0] filter_type, [3] no_previous_line
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,    // [7:0] filtered_byte
    output logic                             m_tlast     // line_end
);

    logic                          q_push;
    pngfe_pkg::entry_t             q_push_entry;
    logic                          q_valid;
    pngfe_pkg::entry_t             q_entry;
    logic                          q_pop_ready;
    logic [pngfe_pkg::Q_CNT_W-1:0] q_level;

    // Accept, track the column and fetch the byte above
    pngfe_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    // Decouple the two stages so each can stall on its own
    pngfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop_ready  (q_pop_ready),
        .out_valid  (q_valid),
        .out_entry  (q_entry),
        .level      (q_level)
    );

    // Predict, subtract and hold the result for the receiver
    pngfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_entry (q_entry),
        .in_ready (q_pop_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for png_scanline_filter_encoder_core: a line-filter predictor
// in a small scoreboard class, stream drivers and the top module tb_top.
// Depends on pngfe_pkg and the core RTL only.
`timescale 1ns / 100ps

class filter_scoreboard #(int LINE_BYTES = 4096);
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } filtered_word_t;

    logic [7:0]     above_bytes [LINE_BYTES];
    bit             above_written [LINE_BYTES];
    logic [7:0]     left_bytes [pngfe_pkg::HIST_DEPTH];
    logic [7:0]     upleft_bytes [pngfe_pkg::HIST_DEPTH];
    int unsigned    column;
    logic [3:0]     bpp_reg;
    logic [12:0]    len_reg;
    filtered_word_t expected_q [$];
    int             errors;
    int             seen;

    function new();
        foreach (left_bytes[i]) begin
            left_bytes[i]   = '0;
            upleft_bytes[i] = '0;
        end
        foreach (above_written[i]) above_written[i] = 1'b0;
        column  = 0;
        bpp_reg = 4'd1;
        len_reg = 13'd1;
        errors  = 0;
        seen    = 0;
    endfunction

    function void write_reg(logic [pngfe_pkg::CFG_IDX_W-1:0] idx,
                            logic [pngfe_pkg::CFG_DATA_W-1:0] value);
        if (idx == pngfe_pkg::REG_BPP) bpp_reg = value[3:0];
        else if (idx == pngfe_pkg::REG_LINE_LEN) len_reg = value;
    endfunction

    function bit above_known();
        return above_written[column];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // nearest of a, b, c to a+b-c; ties go to a, then b
    function int paeth_choice(int a, int b, int c);
        int pa, pb, pc;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    function void note_input(logic [7:0] pixel, logic [2:0] filt, logic no_prev);
        int             step, span, col, a, b, c, pred, h;
        filtered_word_t w;
        step = (bpp_reg == 0) ? 1 : (bpp_reg > pngfe_pkg::MAX_BPP) ? pngfe_pkg::MAX_BPP
                                                                     : bpp_reg;
        span = (len_reg == 0) ? 1 : (len_reg > LINE_BYTES) ? LINE_BYTES : len_reg;
        col  = column;
        a    = 0;
        b    = 0;
        c    = 0;
        if (!no_prev) b = above_bytes[col];
        if (col >= step) begin
            h = (col - step) % pngfe_pkg::HIST_DEPTH;
            a = left_bytes[h];
            c = upleft_bytes[h];
        end
        case (filt)
            pngfe_pkg::FILT_SUB:   pred = a;
            pngfe_pkg::FILT_UP:    pred = b;
            pngfe_pkg::FILT_AVG:   pred = (a + b) >> 1;
            pngfe_pkg::FILT_PAETH: pred = paeth_choice(a, b, c);
            default:               pred = 0;
        endcase
        left_bytes[col % pngfe_pkg::HIST_DEPTH]   = pixel;
        upleft_bytes[col % pngfe_pkg::HIST_DEPTH] = b[7:0];
        above_bytes[col]   = pixel;
        above_written[col] = 1'b1;
        w.last = (col + 1 >= span);
        w.data = pixel - pred[7:0];
        column = w.last ? 0 : col + 1;
        expected_q.push_back(w);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [7:0] data, logic last);
        filtered_word_t w;
        seen++;
        if (expected_q.size() == 0) begin
            flag($sformatf("word %0d arrived with nothing outstanding: data %02h last %0b",
                           seen, data, last));
            return;
        end
        w = expected_q.pop_front();
        if (data !== w.data || last !== w.last)
            flag($sformatf("word %0d mismatch: expected data %02h last %0b, got data %02h last %0b",
                           seen, w.data, w.last, data, last));
    endfunction
endclass

module tb_top;

    localparam int LINE_BYTES = 4096;

    // filter codes the package leaves unnamed; the core treats them as none
    localparam logic [2:0] FILT_UNDEF_5 = 3'd5;
    localparam logic [2:0] FILT_UNDEF_6 = 3'd6;
    localparam logic [2:0] FILT_UNDEF_7 = 3'd7;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [pngfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pngfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;   // [7:0] pixel_byte
    logic [3:0]                       s_tuser   = '0;   // [2:0] filter_type, [3] no_previous_line
    logic                             m_tvalid;
    logic                             m_tready  = 1'b1;
    logic [7:0]                       m_tdata;          // [7:0] filtered_byte
    logic                             m_tlast;

    // idling knobs, percent per cycle; hold_cycles forces a long receiver stall
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    // filter and "no line above" flag chosen at the start of each random line
    logic [2:0] line_filt    = pngfe_pkg::FILT_NONE;
    logic       line_no_prev = 1'b1;

    filter_scoreboard #(LINE_BYTES) sb;

    png_scanline_filter_encoder_core #(
        .MAX_LINE_BYTES (LINE_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("png_scanline_filter_encoder_core verification failed");
        $finish;
    end

    // Receiver: honour a pending hold-off first, otherwise stall at the phase rate.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check every word the core hands over, against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // Write one register; drop cfg_we and wait again before returning so back-to-back writes never clash.
    task automatic write_reg(logic [pngfe_pkg::CFG_IDX_W-1:0] idx,
                             logic [pngfe_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    // Offer one raw byte, idling first at the phase rate; predict it once taken.
    task automatic send_word(logic [7:0] pixel, logic [2:0] filt, logic no_prev);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct && idle < 30) idle++;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= {no_prev, filt};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(pixel, filt, no_prev);
    endtask

    // Drop valid and hold until every predicted word has come back, then let
    // the pipeline run dry.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly defined filters, now and then one of the undefined codes.
    function automatic logic [2:0] pick_filter();
        int v;
        v = $urandom_range(19);
        if (v < 16) return 3'(v % (pngfe_pkg::FILT_PAETH + 1));
        return 3'(FILT_UNDEF_5 + v % 3);
    endfunction

    // Well-formed lines with random bytes; occasionally break the line's
    // filter or flag. Never reference an above byte that was never stored.
    task automatic random_word();
        logic [2:0] filt;
        logic       no_prev;
        if (sb.column == 0) begin
            line_filt    = pick_filter();
            line_no_prev = ($urandom_range(3) == 0);
        end
        filt    = ($urandom_range(9) == 0) ? pick_filter() : line_filt;
        no_prev = line_no_prev ^ ($urandom_range(19) == 0);
        if (!sb.above_known()) no_prev = 1'b1;
        send_word(8'($urandom), filt, no_prev);
    endtask

    // One phase: drain, reconfigure, set idling, then stream random bytes.
    // With squeeze set, stall the receiver for a long stretch a third of the
    // way in, so the queue fills and s_tready drops.
    task automatic run_phase(int step, int span, int send_pct, int recv_pct,
                             int count, bit squeeze);
        settle();
        write_reg(pngfe_pkg::REG_BPP, pngfe_pkg::CFG_DATA_W'(step));
        write_reg(pngfe_pkg::REG_LINE_LEN, pngfe_pkg::CFG_DATA_W'(span));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (squeeze && i == count / 3) hold_cycles = 300;
            random_word();
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 3 bytes per pixel, 6-byte lines.
        write_reg(pngfe_pkg::REG_BPP, pngfe_pkg::CFG_DATA_W'(3));
        write_reg(pngfe_pkg::REG_LINE_LEN, pngfe_pkg::CFG_DATA_W'(6));
        // first line, nothing above: leading columns see a = c = 0
        send_word(8'h00, pngfe_pkg::FILT_NONE,  1'b1);
        send_word(8'hFF, pngfe_pkg::FILT_SUB,   1'b1);
        send_word(8'h80, pngfe_pkg::FILT_UP,    1'b1);
        send_word(8'h01, pngfe_pkg::FILT_AVG,   1'b1);
        send_word(8'hFE, pngfe_pkg::FILT_PAETH, 1'b1);
        send_word(8'h7F, FILT_UNDEF_5,          1'b1);
        // second line reads the first; wrap-around in the subtraction
        send_word(8'hFF, pngfe_pkg::FILT_UP,    1'b0);
        send_word(8'h00, pngfe_pkg::FILT_SUB,   1'b0);
        send_word(8'h00, pngfe_pkg::FILT_UP,    1'b0);
        send_word(8'hFF, pngfe_pkg::FILT_AVG,   1'b0);
        send_word(8'h10, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'h55, FILT_UNDEF_6,          1'b0);
        // Paeth line with both neighbours present
        send_word(8'hAA, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'hAA, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'hAA, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'h33, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'hCC, pngfe_pkg::FILT_PAETH, 1'b0);
        send_word(8'h01, FILT_UNDEF_7,          1'b0);
        // flag "no line above" although the store holds one: b and c read as zero
        send_word(8'h20, pngfe_pkg::FILT_UP,    1'b1);
        send_word(8'h40, pngfe_pkg::FILT_AVG,   1'b1);
        send_word(8'h60, pngfe_pkg::FILT_SUB,   1'b1);
        send_word(8'h80, pngfe_pkg::FILT_PAETH, 1'b1);
        // shorten the line below the current column: the next byte ends it
        settle();
        write_reg(pngfe_pkg::REG_LINE_LEN, pngfe_pkg::CFG_DATA_W'(2));
        send_word(8'hFF, pngfe_pkg::FILT_PAETH, 1'b0);

        // Random phases across idling modes and register extremes; zero and
        // oversized values included.
        run_phase(1,  1,    0,  0,  40,  1'b0);
        run_phase(8,  17,   50, 0,  100, 1'b0);
        run_phase(0,  0,    0,  50, 50,  1'b0);
        run_phase(15, 8191, 0,  0,  90,  1'b0);
        run_phase(4,  37,   26, 26, 150, 1'b1);
        run_phase(9,  5,    0,  50, 70,  1'b0);
        run_phase(2,  12,   26, 26, 120, 1'b0);
        run_phase(7,  3,    0,  0,  100, 1'b1);
        run_phase(6,  100,  26, 26, 80,  1'b0);
        run_phase(5,  10,   50, 0,  50,  1'b0);
        run_phase(3,  4096, 0,  50, 30,  1'b0);

        settle();
        if (sb.errors == 0) begin
            $display("png_scanline_filter_encoder_core verification clean");
        end else begin
            $display("png_scanline_filter_encoder_core verification failed");
        end
        $finish;
    end
endmodule
